// File: hdl/adn_pkg.sv
// ============================================================================
// adn_pkg
// Shared widths, register indexes, reset values and pipeline types for the
// axis deadzone normalizer.
// ============================================================================
package adn_pkg;

    localparam int unsigned SAMPLE_WIDTH = 17;
    localparam int unsigned OUT_W        = 16;

    // Divider geometry: every quotient in this block is known to be below 2**16,
    // so each division takes sixteen restoring steps.
    localparam int unsigned DIV_D_W   = (SAMPLE_WIDTH > 16) ? SAMPLE_WIDTH : 16;
    localparam int unsigned DIV_Q_W   = 16;
    localparam int unsigned DIV_N_W   = DIV_D_W + DIV_Q_W;
    localparam int unsigned DIV_STEPS = DIV_Q_W;
    localparam int unsigned CMP_W     = DIV_D_W + 2;
    localparam int unsigned PROD_W    = 16 + SAMPLE_WIDTH;

    localparam int unsigned S_TDATA_W  = ((SAMPLE_WIDTH + 7) / 8) * 8;
    localparam int unsigned M_TDATA_W  = ((OUT_W + 7) / 8) * 8;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = DIV_D_W;

    localparam logic [CFG_IDX_W-1:0] REG_RAW_MIN    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RAW_MAX    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FLAT_WIDTH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_MIN    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_MAX    = 3'd4;

    localparam logic signed [SAMPLE_WIDTH-1:0] RAW_MIN_RST = SAMPLE_WIDTH'(-32768);
    localparam logic signed [SAMPLE_WIDTH-1:0] RAW_MAX_RST = SAMPLE_WIDTH'(32767);
    localparam logic [15:0]                    FLAT_RST    = 16'd0;
    localparam logic signed [15:0]             OUT_MIN_RST = -16'sd32000;
    localparam logic signed [15:0]             OUT_MAX_RST = 16'sd32000;

    // Which branch of the linear map an item takes.
    typedef enum logic [1:0] {
        SEL_LOW,
        SEL_HIGH,
        SEL_MID
    } sel_t;

    // One lane of the restoring divider: remainder, shifted divisor, quotient.
    typedef struct packed {
        sel_t               sel;
        logic [DIV_N_W-1:0] rem;
        logic [DIV_N_W-1:0] dsh;
        logic [DIV_Q_W-1:0] quo;
    } div_lane_t;

    typedef struct packed {
        logic signed [SAMPLE_WIDTH-1:0] raw_min;
        logic signed [SAMPLE_WIDTH-1:0] raw_max;
        logic [15:0]                    flat_width;
        logic signed [15:0]             out_min;
        logic signed [15:0]             out_max;
    } cfg_t;

    // Values that follow from the configuration alone.
    typedef struct packed {
        logic [15:0]        span_mag;   // |out_max - out_min|
        logic               span_neg;   // out_max < out_min
        logic [DIV_D_W-1:0] raw_span;   // raw_max - raw_min, valid when positive
        logic [15:0]        omax_mag;   // |out_max|
        logic               omax_neg;
        logic [DIV_D_W-1:0] raw_max_u;  // raw_max, valid when positive
        sel_t               thr_sel;
        logic               sym;        // out_min == -out_max
    } cfg_derived_t;

    // Final step of a linear map: pick an end point, or add the signed quotient
    // to the lower end point.
    function automatic logic signed [15:0] map_result(
        input sel_t               sel,
        input logic               neg,
        input logic [15:0]        quo,
        input logic signed [15:0] lo_val,
        input logic signed [15:0] hi_val
    );
        logic signed [17:0] q18;
        logic signed [17:0] sum;
        q18 = {2'b00, quo};
        sum = {{2{lo_val[15]}}, lo_val} + (neg ? (18'sd0 - q18) : q18);
        case (sel)
            SEL_LOW:  map_result = lo_val;
            SEL_HIGH: map_result = hi_val;
            SEL_MID:  map_result = sum[15:0];
            default:  map_result = lo_val;
        endcase
    endfunction

endpackage

// File: hdl/adn_div_step.sv
// ============================================================================
// adn_div_step
// One registered step of the restoring divider: compare, subtract, shift.
// ============================================================================
module adn_div_step
    import adn_pkg::*;
(
    input  logic      aclk,
    input  logic      en,
    input  div_lane_t lane_i,
    output div_lane_t lane_o
);

    div_lane_t lane_reg;
    div_lane_t lane_next;
    logic      fits;

    always_comb begin
        lane_next = lane_i;
        fits      = (lane_i.rem >= lane_i.dsh);
        if (fits) begin
            lane_next.rem = lane_i.rem - lane_i.dsh;
        end
        lane_next.quo = {lane_i.quo[DIV_Q_W-2:0], fits};
        lane_next.dsh = lane_i.dsh >> 1;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            lane_reg <= lane_next;
        end
    end

    assign lane_o = lane_reg;

endmodule

// File: hdl/adn_front.sv
// ============================================================================
// adn_front
// Maps the clamped raw sample onto the output range and, in a parallel lane,
// maps the flat width onto the deadzone threshold.
// ============================================================================
module adn_front
    import adn_pkg::*;
(
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           adv,
    input  logic                           in_valid,
    input  logic signed [SAMPLE_WIDTH-1:0] in_sample,
    input  cfg_t                           cfg,
    input  cfg_derived_t                   dcfg,
    output logic                           out_valid,
    output logic signed [15:0]             out_v,
    output logic signed [15:0]             out_thr
);

    // Range check and offset from the lower raw bound.
    logic signed [SAMPLE_WIDTH-1:0] rmin;
    logic signed [SAMPLE_WIDTH-1:0] rmax;
    logic signed [SAMPLE_WIDTH:0]   xd_full;
    sel_t                           a_sel_next;
    logic                           a_valid_reg;
    sel_t                           a_sel_reg;
    logic [SAMPLE_WIDTH-1:0]        a_xd_reg;

    assign rmin    = cfg.raw_min;
    assign rmax    = cfg.raw_max;
    assign xd_full = {in_sample[SAMPLE_WIDTH-1], in_sample} - {rmin[SAMPLE_WIDTH-1], rmin};

    always_comb begin
        if (in_sample <= rmin) begin
            a_sel_next = SEL_LOW;
        end else if (in_sample >= rmax) begin
            a_sel_next = SEL_HIGH;
        end else begin
            a_sel_next = SEL_MID;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (adv) begin
            a_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            a_sel_reg <= a_sel_next;
            a_xd_reg  <= xd_full[SAMPLE_WIDTH-1:0];
        end
    end

    // Products and divider setup.
    logic [PROD_W-1:0] prod_v;
    logic [31:0]       prod_t;
    div_lane_t         b_lane_v_next;
    div_lane_t         b_lane_t_next;
    logic              b_valid_reg;
    div_lane_t         b_lane_v_reg;
    div_lane_t         b_lane_t_reg;

    assign prod_v = dcfg.span_mag * a_xd_reg;
    assign prod_t = dcfg.omax_mag * cfg.flat_width;

    always_comb begin
        b_lane_v_next     = '0;
        b_lane_v_next.sel = a_sel_reg;
        if (a_sel_reg == SEL_MID) begin
            b_lane_v_next.rem = DIV_N_W'(prod_v);
            b_lane_v_next.dsh = {1'b0, dcfg.raw_span, 15'b0};
        end
        b_lane_t_next     = '0;
        b_lane_t_next.sel = dcfg.thr_sel;
        if (dcfg.thr_sel == SEL_MID) begin
            b_lane_t_next.rem = DIV_N_W'(prod_t);
            b_lane_t_next.dsh = {1'b0, dcfg.raw_max_u, 15'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (adv) begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            b_lane_v_reg <= b_lane_v_next;
            b_lane_t_reg <= b_lane_t_next;
        end
    end

    // Sixteen divider steps for both lanes.
    div_lane_t              lane_v [0:DIV_STEPS];
    div_lane_t              lane_t [0:DIV_STEPS];
    logic [DIV_STEPS-1:0]   c_valid_reg;
    logic [DIV_STEPS-1:0]   c_valid_next;

    assign lane_v[0] = b_lane_v_reg;
    assign lane_t[0] = b_lane_t_reg;

    for (genvar i = 0; i < DIV_STEPS; i++) begin : g_step
        adn_div_step u_step_v (
            .aclk   (aclk),
            .en     (adv),
            .lane_i (lane_v[i]),
            .lane_o (lane_v[i+1])
        );
        adn_div_step u_step_t (
            .aclk   (aclk),
            .en     (adv),
            .lane_i (lane_t[i]),
            .lane_o (lane_t[i+1])
        );
    end

    assign c_valid_next = {c_valid_reg[DIV_STEPS-2:0], b_valid_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            c_valid_reg <= '0;
        end else if (adv) begin
            c_valid_reg <= c_valid_next;
        end
    end

    // Apply the sign and the lower end point.
    logic              d_valid_reg;
    logic signed [15:0] d_v_reg;
    logic signed [15:0] d_thr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            d_valid_reg <= 1'b0;
        end else if (adv) begin
            d_valid_reg <= c_valid_reg[DIV_STEPS-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            d_v_reg   <= map_result(lane_v[DIV_STEPS].sel, dcfg.span_neg,
                                    lane_v[DIV_STEPS].quo, cfg.out_min, cfg.out_max);
            d_thr_reg <= map_result(lane_t[DIV_STEPS].sel, dcfg.omax_neg,
                                    lane_t[DIV_STEPS].quo, 16'sd0, cfg.out_max);
        end
    end

    assign out_valid = d_valid_reg;
    assign out_v     = d_v_reg;
    assign out_thr   = d_thr_reg;

endmodule

// File: hdl/adn_dz.sv
// ============================================================================
// adn_dz
// Removes the deadzone around zero and stretches the rest back to the full
// output range. Skipped when the output range is not symmetric.
// ============================================================================
module adn_dz
    import adn_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               adv,
    input  logic               in_valid,
    input  logic signed [15:0] in_v,
    input  logic signed [15:0] in_thr,
    input  cfg_t               cfg,
    input  cfg_derived_t       dcfg,
    output logic               last_valid,
    output logic signed [15:0] out_value
);

    // Pull toward zero and clip the new range bounds.
    logic signed [17:0] v18;
    logic signed [17:0] t18;
    logic signed [17:0] omin18;
    logic signed [17:0] omax18;
    logic signed [17:0] vp_next;
    logic signed [17:0] lo_next;
    logic signed [17:0] hi_next;
    logic               in_dz;

    assign v18    = {{2{in_v[15]}}, in_v};
    assign t18    = {{2{in_thr[15]}}, in_thr};
    assign omin18 = {{2{cfg.out_min[15]}}, cfg.out_min};
    assign omax18 = {{2{cfg.out_max[15]}}, cfg.out_max};

    always_comb begin
        in_dz = (v18 <= t18) && (v18 >= (18'sd0 - t18));
        if (in_dz) begin
            vp_next = 18'sd0;
        end else if (v18 > 18'sd0) begin
            vp_next = v18 - t18;
        end else begin
            vp_next = v18 + t18;
        end
        lo_next = omin18 + t18;
        if (lo_next > 18'sd0) begin
            lo_next = 18'sd0;
        end
        hi_next = omax18 - t18;
        if (hi_next < 18'sd0) begin
            hi_next = 18'sd0;
        end
    end

    logic               e1_valid_reg;
    logic signed [17:0] e1_vp_reg;
    logic signed [17:0] e1_lo_reg;
    logic signed [17:0] e1_hi_reg;
    logic signed [15:0] e1_v_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e1_valid_reg <= 1'b0;
        end else if (adv) begin
            e1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            e1_vp_reg <= vp_next;
            e1_lo_reg <= lo_next;
            e1_hi_reg <= hi_next;
            e1_v_reg  <= in_v;
        end
    end

    // Branch of the second map, offset and span.
    sel_t               e2_sel_next;
    logic signed [17:0] xd_full;
    logic signed [17:0] span_full;
    logic               e2_valid_reg;
    sel_t               e2_sel_reg;
    logic [15:0]        e2_xd_reg;
    logic [15:0]        e2_span_reg;
    logic signed [15:0] e2_v_reg;

    assign xd_full   = e1_vp_reg - e1_lo_reg;
    assign span_full = e1_hi_reg - e1_lo_reg;

    always_comb begin
        if (e1_vp_reg <= e1_lo_reg) begin
            e2_sel_next = SEL_LOW;
        end else if (e1_vp_reg >= e1_hi_reg) begin
            e2_sel_next = SEL_HIGH;
        end else begin
            e2_sel_next = SEL_MID;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            e2_valid_reg <= 1'b0;
        end else if (adv) begin
            e2_valid_reg <= e1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            e2_sel_reg  <= e2_sel_next;
            e2_xd_reg   <= xd_full[15:0];
            e2_span_reg <= span_full[15:0];
            e2_v_reg    <= e1_v_reg;
        end
    end

    // Product and divider setup.
    logic [31:0]        prod;
    div_lane_t          f_lane_next;
    logic               f_valid_reg;
    div_lane_t          f_lane_reg;
    logic signed [15:0] f_v_reg;

    assign prod = dcfg.span_mag * e2_xd_reg;

    always_comb begin
        f_lane_next     = '0;
        f_lane_next.sel = e2_sel_reg;
        if (e2_sel_reg == SEL_MID) begin
            f_lane_next.rem = DIV_N_W'(prod);
            f_lane_next.dsh = {1'b0, DIV_D_W'(e2_span_reg), 15'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f_valid_reg <= 1'b0;
        end else if (adv) begin
            f_valid_reg <= e2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            f_lane_reg <= f_lane_next;
            f_v_reg    <= e2_v_reg;
        end
    end

    // Divider steps, with the unmapped value carried alongside.
    div_lane_t            lane [0:DIV_STEPS];
    logic [DIV_STEPS-1:0] g_valid_reg;
    logic signed [15:0]   g_v_reg [0:DIV_STEPS-1];

    assign lane[0] = f_lane_reg;

    for (genvar i = 0; i < DIV_STEPS; i++) begin : g_step
        adn_div_step u_step (
            .aclk   (aclk),
            .en     (adv),
            .lane_i (lane[i]),
            .lane_o (lane[i+1])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            g_valid_reg <= '0;
        end else if (adv) begin
            g_valid_reg <= {g_valid_reg[DIV_STEPS-2:0], f_valid_reg};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            g_v_reg[0] <= f_v_reg;
            for (int k = 1; k < DIV_STEPS; k++) begin
                g_v_reg[k] <= g_v_reg[k-1];
            end
        end
    end

    assign last_valid = g_valid_reg[DIV_STEPS-1];
    assign out_value  = dcfg.sym
                      ? map_result(lane[DIV_STEPS].sel, dcfg.span_neg, lane[DIV_STEPS].quo,
                                   cfg.out_min, cfg.out_max)
                      : g_v_reg[DIV_STEPS-1];

endmodule

// File: hdl/axis_deadzone_normalizer.sv
// ============================================================================
// axis_deadzone_normalizer
// Normalizes raw joystick axis samples with a scaled radial deadzone.
// ============================================================================
// Usage: raw samples arrive as items on the s_ stream, one signed sample in
// the low bits of s_tdata. Each item gives exactly one normalized value on the
// m_ stream. Five registers are written through the cfg_ channel, which is
// always ready: 0 raw_min, 1 raw_max, 2 flat_width, 3 out_min, 4 out_max.
// Registers may only be written while no item is in flight.
// Throughput is one item per cycle while no stall holds the pipeline. Items
// pass through two chained sixteen-step restoring dividers, one quotient bit
// per pipeline stage, plus setup, multiply and output stages.
// Reset (aresetn low, synchronous) empties the pipeline and loads the
// register defaults: raw range -32768..32767, no deadzone, output range
// -32000..32000.
// When the receiver stalls, the pipeline keeps moving while its last stage is
// empty, so new items are still taken until the finished item behind the
// output register would have nowhere to go; then s_tready drops and every
// stage holds.
// ============================================================================
module axis_deadzone_normalizer
    import adn_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // Input stream. s_tdata: raw_sample [SAMPLE_WIDTH-1:0], zero padded.
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,
    // Result stream. m_tdata: axis_value [15:0].
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,
    // Configuration write channel.
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    // ------------------------------------------------------------------
    // Configuration registers. Writes to unused indexes are dropped.
    // ------------------------------------------------------------------
    cfg_t cfg_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.raw_min    <= RAW_MIN_RST;
            cfg_reg.raw_max    <= RAW_MAX_RST;
            cfg_reg.flat_width <= FLAT_RST;
            cfg_reg.out_min    <= OUT_MIN_RST;
            cfg_reg.out_max    <= OUT_MAX_RST;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_RAW_MIN:    cfg_reg.raw_min    <= cfg_data[SAMPLE_WIDTH-1:0];
                REG_RAW_MAX:    cfg_reg.raw_max    <= cfg_data[SAMPLE_WIDTH-1:0];
                REG_FLAT_WIDTH: cfg_reg.flat_width <= cfg_data[15:0];
                REG_OUT_MIN:    cfg_reg.out_min    <= cfg_data[15:0];
                REG_OUT_MAX:    cfg_reg.out_max    <= cfg_data[15:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Values derived from the configuration. They are first read one
    // stage after an item enters, so one register here is always settled
    // in time for an item taken right after a write.
    // ------------------------------------------------------------------
    cfg_derived_t                   dcfg_reg;
    cfg_derived_t                   dcfg_next;
    logic signed [16:0]             out_span;
    logic signed [16:0]             out_span_abs;
    logic signed [SAMPLE_WIDTH:0]   raw_diff;
    logic signed [CMP_W-1:0]        flat_x;
    logic signed [CMP_W-1:0]        rmax_x;
    logic signed [17:0]             omin18;
    logic signed [17:0]             omax18;

    always_comb begin
        out_span     = {cfg_reg.out_max[15], cfg_reg.out_max}
                     - {cfg_reg.out_min[15], cfg_reg.out_min};
        out_span_abs = out_span[16] ? (17'sd0 - out_span) : out_span;
        raw_diff     = {cfg_reg.raw_max[SAMPLE_WIDTH-1], cfg_reg.raw_max}
                     - {cfg_reg.raw_min[SAMPLE_WIDTH-1], cfg_reg.raw_min};
        flat_x       = {{(CMP_W-16){1'b0}}, cfg_reg.flat_width};
        rmax_x       = {{(CMP_W-SAMPLE_WIDTH){cfg_reg.raw_max[SAMPLE_WIDTH-1]}},
                        cfg_reg.raw_max};
        omin18       = {{2{cfg_reg.out_min[15]}}, cfg_reg.out_min};
        omax18       = {{2{cfg_reg.out_max[15]}}, cfg_reg.out_max};

        dcfg_next.span_mag  = out_span_abs[15:0];
        dcfg_next.span_neg  = out_span[16];
        dcfg_next.raw_span  = DIV_D_W'(raw_diff[SAMPLE_WIDTH-1:0]);
        dcfg_next.omax_neg  = cfg_reg.out_max[15];
        dcfg_next.omax_mag  = cfg_reg.out_max[15] ? (16'd0 - cfg_reg.out_max)
                                                  : cfg_reg.out_max;
        dcfg_next.raw_max_u = DIV_D_W'(cfg_reg.raw_max[SAMPLE_WIDTH-1:0]);
        // The threshold map tests the low end first: a zero flat width always
        // gives a zero threshold, even when raw_max is not positive.
        if (cfg_reg.flat_width == 16'd0) begin
            dcfg_next.thr_sel = SEL_LOW;
        end else if (flat_x >= rmax_x) begin
            dcfg_next.thr_sel = SEL_HIGH;
        end else begin
            dcfg_next.thr_sel = SEL_MID;
        end
        dcfg_next.sym = (omin18 == (18'sd0 - omax18));
    end

    always_ff @(posedge aclk) begin
        dcfg_reg <= dcfg_next;
    end

    // ------------------------------------------------------------------
    // Pipeline control. All stages move together; they may move while the
    // output register is full as long as the last stage holds no item.
    // ------------------------------------------------------------------
    logic                          adv;
    logic                          out_free;
    logic                          last_valid;
    logic                          front_valid;
    logic signed [15:0]            front_v;
    logic signed [15:0]            front_thr;
    logic signed [15:0]            result;
    logic signed [SAMPLE_WIDTH-1:0] sample;
    logic                          m_tvalid_reg;
    logic                          m_tvalid_next;
    logic [M_TDATA_W-1:0]          m_tdata_reg;

    assign out_free = !m_tvalid_reg || m_tready;
    assign adv      = out_free || !last_valid;
    assign s_tready = adv;
    assign sample   = s_tdata[SAMPLE_WIDTH-1:0];

    adn_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (s_tvalid),
        .in_sample (sample),
        .cfg       (cfg_reg),
        .dcfg      (dcfg_reg),
        .out_valid (front_valid),
        .out_v     (front_v),
        .out_thr   (front_thr)
    );

    adn_dz u_dz (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .adv        (adv),
        .in_valid   (front_valid),
        .in_v       (front_v),
        .in_thr     (front_thr),
        .cfg        (cfg_reg),
        .dcfg       (dcfg_reg),
        .last_valid (last_valid),
        .out_value  (result)
    );

    // ------------------------------------------------------------------
    // Output register.
    // ------------------------------------------------------------------
    always_comb begin
        if (adv && last_valid) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv && last_valid) begin
            m_tdata_reg <= M_TDATA_W'(result);
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // Input back-pressure only comes from a result that the receiver refuses.
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (m_tvalid && !m_tready))
        else $error("s_tready low without a stalled result");

    // A new result appears only when the last pipeline stage held an item.
    a_rise_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> $past(last_valid))
        else $error("result appeared without a finished item");

    // A taken result with nothing behind it leaves the output empty.
    a_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && !last_valid) |=> !m_tvalid)
        else $error("result repeated after it was taken");

endmodule

// File: tb/sv/adn_result_checker.sv
`timescale 1ns / 100ps
// ============================================================================
// adn_result_checker
// Watches the register channel and both streams of the axis deadzone
// normalizer. It predicts the normalized value of every accepted raw sample
// and compares each delivered value against the oldest prediction.
// ============================================================================
module adn_result_checker
    import adn_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [M_TDATA_W-1:0]  m_tdata,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    mismatches,
    output int                    pending,
    output int                    compared,
    output int                    zero_results
);

    typedef struct {
        logic signed [SAMPLE_WIDTH-1:0] raw;
        logic signed [15:0]             axis;
    } axis_expect_t;

    cfg_t         settings;
    axis_expect_t expected_axis_q[$];

    // Clamped linear map of x from v0..v1 onto o0..o1. The lower test comes
    // first, so the divisor is positive whenever the division is reached.
    function automatic longint linear_ramp(input longint x, input longint v0,
                                           input longint v1, input longint o0,
                                           input longint o1);
        if (x <= v0)
            return o0;
        if (x >= v1)
            return o1;
        return o0 + (o1 - o0) * (x - v0) / (v1 - v0);
    endfunction

    function automatic logic signed [15:0] normalize_sample(
        input cfg_t                           c,
        input logic signed [SAMPLE_WIDTH-1:0] raw
    );
        longint rlo, rhi, olo, ohi, thr, v, lo, hi;
        rlo = longint'(c.raw_min);
        rhi = longint'(c.raw_max);
        olo = longint'(c.out_min);
        ohi = longint'(c.out_max);
        thr = linear_ramp(longint'(c.flat_width), 0, rhi, 0, ohi);
        v   = linear_ramp(longint'(raw), rlo, rhi, olo, ohi);
        // The deadzone only applies to a symmetric output range.
        if (olo == -ohi) begin
            if (v <= thr && v >= -thr)
                v = 0;
            else if (v > 0)
                v = v - thr;
            else
                v = v + thr;
            lo = (olo + thr > 0) ? 0 : olo + thr;
            hi = (ohi - thr < 0) ? 0 : ohi - thr;
            v  = linear_ramp(v, lo, hi, olo, ohi);
        end
        return v[15:0];
    endfunction

    always @(posedge aclk) begin
        axis_expect_t       want;
        logic signed [15:0] got;
        if (!aresetn) begin
            settings = '{raw_min: RAW_MIN_RST, raw_max: RAW_MAX_RST, flat_width: FLAT_RST,
                         out_min: OUT_MIN_RST, out_max: OUT_MAX_RST};
            expected_axis_q.delete();
            mismatches   = 0;
            compared     = 0;
            zero_results = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_RAW_MIN:    settings.raw_min    = cfg_data[SAMPLE_WIDTH-1:0];
                    REG_RAW_MAX:    settings.raw_max    = cfg_data[SAMPLE_WIDTH-1:0];
                    REG_FLAT_WIDTH: settings.flat_width = cfg_data[15:0];
                    REG_OUT_MIN:    settings.out_min    = cfg_data[15:0];
                    REG_OUT_MAX:    settings.out_max    = cfg_data[15:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                want.raw  = s_tdata[SAMPLE_WIDTH-1:0];
                want.axis = normalize_sample(settings, want.raw);
                expected_axis_q.insert(expected_axis_q.size(), want);
            end
            if (m_tvalid && m_tready) begin
                got = m_tdata[15:0];
                if (expected_axis_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected result axis_value=%0d", $time, got);
                end else begin
                    want = expected_axis_q.pop_front();
                    compared++;
                    if (want.axis == 0)
                        zero_results++;
                    if (got !== want.axis) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("%0t: raw_sample=%0d axis_value expected %0d, got %0d",
                                     $time, want.raw, want.axis, got);
                    end
                end
            end
        end
        pending = expected_axis_q.size();
    end

endmodule

// File: tb/sv/axis_deadzone_normalizer_test.sv
`timescale 1ns / 100ps
// ============================================================================
// axis_deadzone_normalizer_test
// Drives raw samples through the normalizer under a series of register
// settings, with random gaps on the input and random stalls on the output,
// and leaves prediction and comparison to the result checker.
// ============================================================================
module axis_deadzone_normalizer_test;
    import adn_pkg::*;

    // Number of random samples after the directed part.
    localparam int unsigned RANDOM_ITEMS = 1750;
    // Long output stall used to fill the pipeline and push back on the input.
    localparam int unsigned HOLD_CYCLES  = 400;
    // Quiet time after the last result; well above the pipeline latency.
    localparam int unsigned DRAIN_CYCLES = 60;
    // Hard stop for the whole run, in nanoseconds.
    localparam longint      TIMEOUT_NS   = 1_000_000;

    typedef enum int {
        READY_ALWAYS,
        READY_MOSTLY,
        READY_PATTERN,
        READY_SPARSE
    } ready_style_t;

    typedef enum int {
        FLOW_STEADY,
        FLOW_BURSTY,
        FLOW_TRICKLE
    } flow_style_t;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_tvalid  = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata   = '0;
    logic                  m_tvalid;
    logic                  m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    int mismatches;
    int pending;
    int compared;
    int zero_results;

    // The settings currently loaded, kept here only to aim samples at the
    // interesting spots (deadzone edges and the ends of the raw range).
    int cur_raw_min = -32768;
    int cur_raw_max = 32767;
    int cur_flat    = 0;
    int cur_out_min = -32000;
    int cur_out_max = 32000;

    ready_style_t ready_style = READY_ALWAYS;
    flow_style_t  flow_style  = FLOW_STEADY;

    int burst_left     = 0;
    int hold_asked     = 0;
    int hold_taken     = 0;
    int hold_left      = 0;
    int ready_tick     = 0;
    int items_sent     = 0;
    int settings_used  = 1;

    axis_deadzone_normalizer uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    adn_result_checker axis_check (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .mismatches   (mismatches),
        .pending      (pending),
        .compared     (compared),
        .zero_results (zero_results)
    );

    // 2 ns clock.
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Safety net: a correct run finishes far earlier than this.
    initial begin
        #TIMEOUT_NS;
        $display("status: fail");
        $finish;
    end

    // Output side. A requested hold takes priority and is counted down here;
    // otherwise the ready line follows the style chosen for the phase.
    always @(negedge aclk) begin
        ready_tick <= ready_tick + 1;
        if (hold_left > 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_asked != hold_taken) begin
            m_tready   <= 1'b0;
            hold_taken <= hold_taken + 1;
            hold_left  <= HOLD_CYCLES - 1;
        end else begin
            case (ready_style)
                READY_ALWAYS:  m_tready <= 1'b1;
                READY_MOSTLY:  m_tready <= ($urandom_range(0, 3) != 0);
                READY_PATTERN: m_tready <= ((ready_tick % 11) < 7);
                default:       m_tready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    function automatic int rand_between(input int lo, input int hi);
        return lo + int'($urandom_range(0, hi - lo));
    endfunction

    function automatic int clamp_raw(input longint v);
        if (v < -65536)
            return -65536;
        if (v > 65535)
            return 65535;
        return int'(v);
    endfunction

    // One register write; the channel stays valid if the caller writes again
    // at the next falling edge.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    // Loads all five registers from the cur_ copies. The 16-bit registers get
    // random upper data bits, which the block must ignore. An optional write
    // to an unused index comes first; it must change nothing.
    task automatic apply_settings(input bit junk_write);
        logic [CFG_DATA_W-1:0] data;
        if (junk_write) begin
            data = CFG_DATA_W'($urandom);
            write_reg(REG_OUT_MAX + CFG_IDX_W'($urandom_range(1, 3)), data);
        end
        write_reg(REG_RAW_MIN, CFG_DATA_W'(cur_raw_min));
        write_reg(REG_RAW_MAX, CFG_DATA_W'(cur_raw_max));
        data = CFG_DATA_W'($urandom);
        data[15:0] = 16'(cur_flat);
        write_reg(REG_FLAT_WIDTH, data);
        data = CFG_DATA_W'($urandom);
        data[15:0] = 16'(cur_out_min);
        write_reg(REG_OUT_MIN, data);
        data = CFG_DATA_W'($urandom);
        data[15:0] = 16'(cur_out_max);
        write_reg(REG_OUT_MAX, data);
        @(negedge aclk);
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    task automatic use_settings(input int rmin, input int rmax, input int flat,
                                input int omin, input int omax, input bit junk_write);
        cur_raw_min = rmin;
        cur_raw_max = rmax;
        cur_flat    = flat;
        cur_out_min = omin;
        cur_out_max = omax;
        apply_settings(junk_write);
    endtask

    // Random settings with weight on the corner cases: the full and default
    // raw ranges, tiny spans, empty and inverted ranges, a non-positive
    // raw_max, symmetric output ranges of either sign, and flat widths at or
    // beyond raw_max.
    task automatic choose_settings();
        int a;
        int b;
        case ($urandom_range(0, 9))
            0: begin cur_raw_min = -65536; cur_raw_max = 65535; end
            1: begin cur_raw_min = -32768; cur_raw_max = 32767; end
            2: begin
                cur_raw_min = rand_between(-65536, 65000);
                cur_raw_max = cur_raw_min + rand_between(1, 20);
            end
            3: begin
                cur_raw_min = rand_between(-65536, 65535);
                cur_raw_max = cur_raw_min;
            end
            4: begin
                cur_raw_max = rand_between(-65536, 65000);
                cur_raw_min = rand_between(cur_raw_max + 1, 65535);
            end
            5: begin
                cur_raw_max = -rand_between(0, 65000);
                cur_raw_min = clamp_raw(longint'(cur_raw_max) - rand_between(1, 1000));
            end
            default: begin
                a = rand_between(-65536, 65535);
                b = rand_between(-65536, 65535);
                if (a == b)
                    b = (a == 65535) ? a - 1 : a + 1;
                cur_raw_min = (a < b) ? a : b;
                cur_raw_max = (a < b) ? b : a;
            end
        endcase
        case ($urandom_range(0, 9))
            6: begin cur_out_min = -32768; cur_out_max = 32767; end
            7: begin cur_out_min = 32767;  cur_out_max = -32768; end
            8: begin cur_out_min = rand_between(-32768, 32767); cur_out_max = -32768; end
            9: begin
                cur_out_min = rand_between(-32768, 32767);
                cur_out_max = rand_between(-32768, 32767);
            end
            default: begin
                if ($urandom_range(0, 5) == 0)
                    cur_out_max = ($urandom_range(0, 1) != 0) ? 32767 : -32767;
                else
                    cur_out_max = rand_between(-32767, 32767);
                cur_out_min = -cur_out_max;
            end
        endcase
        case ($urandom_range(0, 9))
            0, 1, 2: cur_flat = 0;
            3, 4, 5: cur_flat = rand_between(0, (cur_raw_max > 0) ? cur_raw_max : 100);
            6:       cur_flat = (cur_raw_max > 0) ? clamp_raw(longint'(cur_raw_max)
                                + rand_between(0, 3)) : rand_between(0, 10);
            7:       cur_flat = 65535;
            default: cur_flat = rand_between(0, 65535);
        endcase
        if (cur_flat > 65535)
            cur_flat = 65535;
    endtask

    // Sample mix: the full field range, the configured raw range, the raw
    // positions that map onto the deadzone edges, and the raw range ends.
    function automatic int pick_sample();
        longint mid;
        longint dz_off;
        int     r;
        r = $urandom_range(0, 19);
        if (r < 5)
            return rand_between(-65536, 65535);
        if (r < 12) begin
            if (cur_raw_max > cur_raw_min)
                return rand_between(cur_raw_min, cur_raw_max);
            return rand_between(-65536, 65535);
        end
        if (r < 17) begin
            mid    = (longint'(cur_raw_min) + cur_raw_max) / 2;
            dz_off = (cur_raw_max > 0)
                   ? longint'(cur_flat) * (longint'(cur_raw_max) - cur_raw_min)
                     / (2 * longint'(cur_raw_max))
                   : 0;
            if ($urandom_range(0, 1) != 0)
                dz_off = -dz_off;
            return clamp_raw(mid + dz_off + rand_between(-3, 3));
        end
        return clamp_raw(longint'(($urandom_range(0, 1) != 0) ? cur_raw_max : cur_raw_min)
                         + rand_between(-2, 2));
    endfunction

    // Offers one sample and waits for it to be taken. Gaps are inserted
    // between bursts according to the phase's flow style.
    task automatic offer_sample(input int value);
        logic [SAMPLE_WIDTH-1:0] raw_bits;
        int                      gap;
        raw_bits = SAMPLE_WIDTH'(value);
        gap      = 0;
        if (burst_left <= 0) begin
            case (flow_style)
                FLOW_STEADY: burst_left = 1_000_000;
                FLOW_BURSTY: begin
                    burst_left = rand_between(1, 8);
                    gap        = rand_between(1, 4);
                end
                default: begin
                    burst_left = rand_between(1, 3);
                    gap        = rand_between(0, 12);
                end
            endcase
            if (gap > 0) begin
                @(negedge aclk);
                s_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'(raw_bits);
        do @(posedge aclk); while (!s_tready);
        burst_left--;
        items_sent++;
    endtask

    // Ends a phase: the input goes idle and every predicted value has to come
    // out before the registers may be touched again.
    task automatic finish_phase();
        @(negedge aclk);
        s_tvalid   <= 1'b0;
        burst_left  = 0;
        while (pending != 0)
            @(negedge aclk);
    endtask

    initial begin
        int d_default[8]  = '{-65536, 65535, -32768, 32767, 0, -1, 1, 32768};
        int d_deadzone[7] = '{0, 7990, 8200, -8200, -8100, 32767, -32768};
        int d_asym[4]     = '{-65536, 65535, 1, -1};
        int d_inverted[3] = '{100, 101, -200};
        int d_negative[3] = '{-500, -255, -10};
        int target;
        int phase_no;
        int phase_items;

        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part. First the reset settings, with samples at the field
        // extremes and around the raw range ends.
        foreach (d_default[i])
            offer_sample(d_default[i]);
        finish_phase();

        // Symmetric output range with a deadzone; samples straddle both edges.
        use_settings(-32768, 32767, 8000, -32000, 32000, 1'b1);
        foreach (d_deadzone[i])
            offer_sample(d_deadzone[i]);
        finish_phase();

        // Widest raw range onto a non-symmetric output range: no deadzone.
        use_settings(-65536, 65535, 65535, -32768, 32767, 1'b0);
        foreach (d_asym[i])
            offer_sample(d_asym[i]);
        finish_phase();

        // Inverted raw range: only the lower test or out_max can be given.
        use_settings(100, -100, 50, -1000, 1000, 1'b1);
        foreach (d_inverted[i])
            offer_sample(d_inverted[i]);
        finish_phase();

        // Symmetric range with negative out_max and a non-positive raw_max,
        // where flat_width at or above raw_max gives threshold out_max.
        use_settings(-500, -10, 5, 1000, -1000, 1'b0);
        foreach (d_negative[i])
            offer_sample(d_negative[i]);
        finish_phase();

        // Random part. The first phase streams without gaps into a long
        // output stall so the pipeline fills and the input is pushed back.
        target   = items_sent + RANDOM_ITEMS;
        phase_no = 0;
        while (items_sent < target) begin
            choose_settings();
            apply_settings($urandom_range(0, 4) == 0);
            if (phase_no == 0) begin
                ready_style = READY_ALWAYS;
                flow_style  = FLOW_STEADY;
                phase_items = 200;
            end else begin
                ready_style = ready_style_t'($urandom_range(0, 3));
                flow_style  = flow_style_t'($urandom_range(0, 2));
                phase_items = rand_between(60, 180);
            end
            if (phase_items > target - items_sent)
                phase_items = target - items_sent;
            if (phase_no == 0 || $urandom_range(0, 9) == 0)
                hold_asked++;
            repeat (phase_items)
                offer_sample(pick_sample());
            finish_phase();
            phase_no++;
        end

        // Anything arriving now would be an unexpected result.
        repeat (DRAIN_CYCLES) @(negedge aclk);

        $display("run covered %0d samples under %0d register settings, %0d long stalls",
                 items_sent, settings_used, hold_asked);
        $display("%0d results compared, %0d of them zero, %0d mismatches",
                 compared, zero_results, mismatches);
        if (mismatches == 0 && pending == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
